// File: hw/rtl/table_linear_interpolator_core_assert.svh
// Assertion helpers shared by the interpolator RTL.
`ifndef TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLI_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tli_pkg.sv
package tli_pkg;

	localparam int VW         = 32;         // Q16.16 value width
	localparam int PW         = 2 * VW;     // product width
	localparam int QW         = VW + 2;     // quotient bits produced by the divider
	localparam int DIV_STEPS  = QW / 2;     // radix-4 digits
	localparam int IDX_W      = 6;
	localparam int LEN_W      = 7;
	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 3;

	// Largest quotient that still adds to the base without forced saturation.
	localparam logic [QW-1:0] QUOT_LIMIT = {{(QW - VW - 1){1'b0}}, 1'b1, {VW{1'b0}}};

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REGION_EXACT  = 2'd0,
		REGION_INTERP = 2'd1,
		REGION_BELOW  = 2'd2,
		REGION_ABOVE  = 2'd3
	} region_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_CLASSIFY,
		ST_PROBE,
		ST_COMPARE,
		ST_PAIR_A,
		ST_PAIR_B,
		ST_PAIR_C,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic          start;
		logic [PW-1:0] dividend;
		logic [VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic          ovf;
		logic [QW-1:0] quot;
	} div_rsp_t;

endpackage

// File: hw/rtl/table_linear_interpolator_core.sv
// Write transaction: taken whenever the sequencer is idle.
// Query: the below/above cases go straight to the pair reads; an interpolated point first
// takes P binary-search probes (up to log2(table_length) + 1), as does an exact hit, which
// ends at its matching probe; a zero span skips the divide. One query in flight at a time,
// set by the single-port point memory and the radix-4 divider.
// Reset clears the sequencer, the output register and table_length (to 2); points are undefined until written.
`include "table_linear_interpolator_core_assert.svh"

module table_linear_interpolator_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: table_length
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tli_pkg::LEN_W-1:0]        cfg_data,
	// input items
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [5:0] entry_index, [37:6] x_value, [69:38] y_value, [71:70] zero
	input  logic [tli_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [0] command
	input  logic [tli_pkg::IN_USER_W-1:0]    s_axis_tuser,
	// results
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] interpolated_value
	output logic [tli_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// [1:0] region, [2] zero_span
	output logic [tli_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
	import tli_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = AW + 1;                           // search bounds reach TABLE_DEPTH
	localparam int NW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
	localparam int MW = 2 * VW;                           // one point: {y, x}
	localparam int SW = QW + 1;

	localparam logic [VW-1:0] VMAX = {1'b0, {(VW - 1){1'b1}}};
	localparam logic [VW-1:0] VMIN = {1'b1, {(VW - 1){1'b0}}};

	// magnitude of p - m; the sign is p < m
	function automatic logic [VW-1:0] mag_diff(input logic signed [VW-1:0] p,
		input logic signed [VW-1:0] m);
		logic [VW:0] d;
		if (p < m) begin
			d = {m[VW-1], m} - {p[VW-1], p};
		end else begin
			d = {p[VW-1], p} - {m[VW-1], m};
		end
		return d[VW-1:0];
	endfunction

	// ---------------------------------------------------------------- input fields
	logic                    in_acc;
	logic                    in_cmd;
	logic [IDX_W-1:0]        in_idx;
	logic signed [VW-1:0]    in_x;
	logic signed [VW-1:0]    in_y;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_cmd = s_axis_tuser[0];
	assign in_idx = s_axis_tdata[IDX_W-1:0];
	assign in_x   = s_axis_tdata[IDX_W +: VW];
	assign in_y   = s_axis_tdata[IDX_W + VW +: VW];

	// ---------------------------------------------------------------- configuration
	logic [LEN_W-1:0] table_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= LEN_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			table_length_q <= cfg_data;
		end
	end

	// Clamp the length to 2 .. TABLE_DEPTH and keep only the last index.
	logic [NW-1:0] len_ext;
	logic [NW-1:0] len_clamp;
	logic [NW-1:0] len_m1;
	logic [AW-1:0] last_nxt;

	always_comb begin
		len_ext = NW'(table_length_q);
		if (len_ext < NW'(2)) begin
			len_clamp = NW'(2);
		end else if (len_ext > NW'(TABLE_DEPTH)) begin
			len_clamp = NW'(TABLE_DEPTH);
		end else begin
			len_clamp = len_ext;
		end
		len_m1   = len_clamp - NW'(1);
		last_nxt = len_m1[AW-1:0];
	end

	// ---------------------------------------------------------------- point memory
	// One synchronous read port, one write port. Writes are only taken in idle,
	// and every read belongs to a running query, so no forwarding is needed.
	logic [MW-1:0]        mem [TABLE_DEPTH];
	logic [MW-1:0]        rd_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic signed [VW-1:0] rd_x;
	logic signed [VW-1:0] rd_y;

	// drop writes that land beyond the table
	assign wr_en   = in_acc && (in_cmd == CMD_WRITE) && (NW'(in_idx) < NW'(TABLE_DEPTH));
	assign wr_addr = AW'(in_idx);
	assign rd_x    = rd_q[VW-1:0];
	assign rd_y    = rd_q[MW-1:VW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {in_y, in_x};
		end
		rd_q <= mem[rd_addr];
	end

	// ---------------------------------------------------------------- query state
	state_t               state_q;
	state_t               state_nxt;
	logic signed [VW-1:0] q_q;
	logic [AW-1:0]        last_q;
	logic signed [VW-1:0] x0_q;
	logic [IW-1:0]        lo_q;
	logic [IW-1:0]        hi_q;
	logic [IW-1:0]        mid_q;
	logic                 lt_q;
	logic [AW-1:0]        a_q;
	logic [AW-1:0]        b_q;
	logic signed [VW-1:0] xa_q;
	logic signed [VW-1:0] ya_q;
	region_t              region_q;
	logic                 zs_q;
	logic [VW-1:0]        res_q;
	logic [VW-1:0]        base_q;
	logic [VW-1:0]        dq_mag_q;
	logic [VW-1:0]        dy_mag_q;
	logic [VW-1:0]        dx_mag_q;
	logic                 neg_q;
	logic [PW-1:0]        prod_q;

	logic                 m_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;
	logic                 out_free;
	logic                 out_load;
	logic                 div_start;

	div_req_t             div_req;
	div_rsp_t             div_rsp;

	// Binary-search midpoint.
	logic [IW:0]   mid_sum;
	logic [IW-1:0] mid_c;
	logic [IW-1:0] mid_fix;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c   = mid_sum[IW:1];
	// search ran out: step right when the last probe was below the query
	assign mid_fix = (lt_q && (mid_q < IW'(last_q))) ? mid_q + IW'(1) : mid_q;

	// Pair operands. The below case works from the first point, all others
	// from the higher-index point of the pair.
	logic                 below;
	logic signed [VW-1:0] base_c;
	logic signed [VW-1:0] xr_c;
	logic signed [VW-1:0] yp_c;
	logic signed [VW-1:0] ym_c;
	logic signed [VW-1:0] xp_c;
	logic signed [VW-1:0] xm_c;

	always_comb begin
		below  = (region_q == REGION_BELOW);
		base_c = below ? ya_q : rd_y;
		xr_c   = below ? xa_q : rd_x;
		yp_c   = below ? rd_y : ya_q;
		ym_c   = below ? ya_q : rd_y;
		xp_c   = below ? rd_x : xa_q;
		xm_c   = below ? xa_q : rd_x;
	end

	// Final add and saturation from the divider result.
	logic [SW-1:0] base_ext;
	logic [SW-1:0] quot_ext;
	logic [SW-1:0] sum;
	logic          big;
	logic [VW-1:0] sum_sat;

	always_comb begin
		base_ext = {{(SW - VW){base_q[VW-1]}}, base_q};
		quot_ext = {1'b0, div_rsp.quot};
		sum      = neg_q ? base_ext - quot_ext : base_ext + quot_ext;
		big      = div_rsp.ovf || (div_rsp.quot > QUOT_LIMIT);
		if (big) begin
			sum_sat = neg_q ? VMIN : VMAX;
		end else if ((&sum[SW-1:VW-1]) || !(|sum[SW-1:VW-1])) begin
			sum_sat = sum[VW-1:0];
		end else begin
			sum_sat = sum[SW-1] ? VMIN : VMAX;
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_cmd == CMD_QUERY) begin
					state_nxt = ST_RD_FIRST;
				end
			end
			ST_RD_FIRST: state_nxt = ST_RD_LAST;
			ST_RD_LAST:  state_nxt = ST_CLASSIFY;
			ST_CLASSIFY: begin
				if (q_q <= x0_q || q_q > rd_x) begin
					state_nxt = ST_PAIR_A;
				end else begin
					state_nxt = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (lo_q <= hi_q) begin
					state_nxt = ST_COMPARE;
				end else begin
					state_nxt = ST_PAIR_A;
				end
			end
			ST_COMPARE: begin
				if (rd_x == q_q) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_PROBE;
				end
			end
			ST_PAIR_A: state_nxt = ST_PAIR_B;
			ST_PAIR_B: state_nxt = ST_PAIR_C;
			ST_PAIR_C: begin
				if (rd_x == xa_q) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL:    state_nxt = ST_DIV_GO;
			ST_DIV_GO: state_nxt = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rd_addr       = '0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE:     s_axis_tready = 1'b1;
			ST_RD_FIRST: rd_addr = '0;
			ST_RD_LAST:  rd_addr = last_q;
			ST_PROBE:    rd_addr = mid_c[AW-1:0];
			ST_PAIR_A:   rd_addr = a_q;
			ST_PAIR_B:   rd_addr = b_q;
			ST_DIV_GO:   div_start = 1'b1;
			ST_FINISH:   out_load = out_free;
			default:     rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Datapath registers: advance per state, hold otherwise.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					q_q    <= in_x;
					last_q <= last_nxt;
				end
			end
			ST_RD_LAST: x0_q <= rd_x;
			ST_CLASSIFY: begin
				// rd_q holds the last point here
				if (q_q <= x0_q) begin
					region_q <= REGION_BELOW;
					a_q      <= '0;
					b_q      <= AW'(1);
				end else if (q_q > rd_x) begin
					region_q <= REGION_ABOVE;
					a_q      <= last_q - AW'(1);
					b_q      <= last_q;
				end else begin
					region_q <= REGION_INTERP;
					lo_q     <= IW'(1);
					hi_q     <= IW'(last_q);
				end
			end
			ST_PROBE: begin
				if (lo_q <= hi_q) begin
					mid_q <= mid_c;
				end else begin
					a_q <= AW'(mid_fix - IW'(1));
					b_q <= AW'(mid_fix);
				end
			end
			ST_COMPARE: begin
				lt_q <= rd_x < q_q;
				if (rd_x < q_q) begin
					lo_q <= mid_q + IW'(1);
				end else if (rd_x > q_q) begin
					hi_q <= mid_q - IW'(1);
				end else begin
					res_q    <= rd_y;
					region_q <= REGION_EXACT;
					zs_q     <= 1'b0;
				end
			end
			ST_PAIR_B: begin
				xa_q <= rd_x;
				ya_q <= rd_y;
			end
			ST_PAIR_C: begin
				// equal abscissas: return the higher-index ordinate
				zs_q     <= (rd_x == xa_q);
				res_q    <= rd_y;
				base_q   <= base_c;
				dq_mag_q <= mag_diff(q_q, xr_c);
				dy_mag_q <= mag_diff(yp_c, ym_c);
				dx_mag_q <= mag_diff(xp_c, xm_c);
				neg_q    <= (q_q < xr_c) ^ (yp_c < ym_c) ^ (xp_c < xm_c);
			end
			ST_MUL: prod_q <= dq_mag_q * dy_mag_q;
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					res_q <= sum_sat;
				end
			end
			default: ;
		endcase
	end

	assign div_req.start    = div_start;
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = dx_mag_q;

	tli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_q;
			out_user_q <= {zs_q, region_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	`TLI_ASSERT_NXT(a_query_starts_read, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_QUERY, state_q == ST_RD_FIRST, "query transaction did not start a table read")
	`TLI_ASSERT_IMP(a_probe_in_range, clk, arst_n, state_q == ST_PROBE && lo_q <= hi_q, mid_c <= IW'(last_q) && mid_c != '0, "search probe outside the table")
	`TLI_ASSERT_IMP(a_pair_adjacent, clk, arst_n, state_q == ST_PAIR_A, b_q == a_q + AW'(1), "interpolation pair not adjacent")
	`TLI_ASSERT_IMP(a_zero_span_not_exact, clk, arst_n, out_load, !(zs_q && region_q == REGION_EXACT), "zero span flagged on an exact hit")

endmodule

// File: hw/rtl/tli_div.sv
`include "table_linear_interpolator_core_assert.svh"

// Radix-4 restoring divider, unsigned 64 / 32. Produces the low QW quotient
// bits; ovf flags a quotient that does not fit in QW bits.
module tli_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tli_pkg::div_req_t req,
	output tli_pkg::div_rsp_t rsp
);
	import tli_pkg::*;

	localparam int CW = $clog2(DIV_STEPS + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW+1:0] dvs3_q;
	logic [QW-1:0] num_q;
	logic [QW-1:0] quot_q;

	logic [VW+1:0] rem4;
	logic [VW+2:0] t1;
	logic [VW+2:0] t2;
	logic [VW+2:0] t3;
	logic [1:0]    digit;
	logic [VW-1:0] rem_nxt;

	assign rem4 = {rem_q, num_q[QW-1 -: 2]};
	assign t1   = {1'b0, rem4} - {3'b000, dvs_q};
	assign t2   = {1'b0, rem4} - {2'b00, dvs_q, 1'b0};
	assign t3   = {1'b0, rem4} - {1'b0, dvs3_q};

	// pick the largest multiple that does not borrow
	always_comb begin
		if (!t3[VW+2]) begin
			digit   = 2'd3;
			rem_nxt = t3[VW-1:0];
		end else if (!t2[VW+2]) begin
			digit   = 2'd2;
			rem_nxt = t2[VW-1:0];
		end else if (!t1[VW+2]) begin
			digit   = 2'd1;
			rem_nxt = t1[VW-1:0];
		end else begin
			digit   = 2'd0;
			rem_nxt = rem4[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= VW'(req.dividend[PW-1:QW]);
			num_q  <= req.dividend[QW-1:0];
			dvs_q  <= req.divisor;
			dvs3_q <= {2'b00, req.divisor} + {1'b0, req.divisor, 1'b0};
			ovf_q  <= VW'(req.dividend[PW-1:QW]) >= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			num_q  <= {num_q[QW-3:0], 2'b00};
			quot_q <= {quot_q[QW-3:0], digit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = quot_q;

	`TLI_ASSERT_IMP(a_div_start_idle, clk, arst_n, req.start, !busy_q, "divider restarted while busy")
	`TLI_ASSERT_NXT(a_div_done_last, clk, arst_n, busy_q && !req.start && cnt_q == CW'(1), done_q && !busy_q, "divider missed its last digit")

endmodule

// File: bench/interp_checker.sv
module interp_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tli_pkg::LEN_W-1:0]      cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [tli_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [tli_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [tli_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [tli_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output int                             mismatches,
	output int                             outstanding
);
	import tli_pkg::*;

	localparam int     POINTS_MAX = 64;
	localparam longint VAL_MAX    = 64'sd2147483647;
	localparam longint VAL_MIN    = -64'sd2147483648;

	typedef struct {
		logic [VW-1:0] value;
		region_t       region;
		logic          zero_span;
	} query_result_t;

	longint        pt_x [POINTS_MAX];
	longint        pt_y [POINTS_MAX];
	int            points_in_use = 2;
	query_result_t awaited_results [$];

	function automatic longint clip(longint v);
		if (v > VAL_MAX)
			return VAL_MAX;
		if (v < VAL_MIN)
			return VAL_MIN;
		return v;
	endfunction

	function automatic logic [63:0] mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// base + trunc(dq * dy / dx), saturated; dx is never zero here
	function automatic longint slope_point(longint base, longint dq, longint dy, longint dx);
		logic        neg;
		logic [63:0] mq, my, mx, quot;
		neg  = ((dq < 0) != (dy < 0)) != (dx < 0);
		mq   = mag(dq);
		my   = mag(dy);
		mx   = mag(dx);
		quot = (mq * my) / mx;
		if (quot > 64'h1_0000_0000)
			return neg ? VAL_MIN : VAL_MAX;
		if (neg)
			return clip(base - longint'(quot));
		return clip(base + longint'(quot));
	endfunction

	function automatic void span_pair(int a, int b, longint base, longint q,
			output longint r, output logic zs);
		longint dx;
		dx = pt_x[a] - pt_x[b];
		if (dx == 0) begin
			r  = pt_y[b];
			zs = 1'b1;
			return;
		end
		if (a == 0 && b == 1 && base == pt_y[0] && q <= pt_x[0])
			r = slope_point(base, q - pt_x[0], pt_y[1] - pt_y[0], pt_x[1] - pt_x[0]);
		else
			r = slope_point(base, q - pt_x[b], pt_y[a] - pt_y[b], dx);
		zs = 1'b0;
	endfunction

	function automatic query_result_t predict_query(longint q);
		query_result_t res;
		int            n, last, lo, hi, mid;
		bit            hit;
		longint        r;
		logic          zs;
		n = points_in_use;
		if (n < 2)
			n = 2;
		if (n > POINTS_MAX)
			n = POINTS_MAX;
		last = n - 1;
		r    = 0;
		zs   = 1'b0;
		hit  = 1'b0;
		if (q <= pt_x[0]) begin
			res.region = REGION_BELOW;
			span_pair(0, 1, pt_y[0], q, r, zs);
		end else if (q > pt_x[last]) begin
			res.region = REGION_ABOVE;
			span_pair(last - 1, last, pt_y[last], q, r, zs);
		end else begin
			lo  = 1;
			hi  = last;
			mid = 1;
			while (lo <= hi && !hit) begin
				mid = (lo + hi) / 2;
				if (pt_x[mid] < q)
					lo = mid + 1;
				else if (pt_x[mid] > q)
					hi = mid - 1;
				else
					hit = 1'b1;
			end
			if (hit) begin
				res.region = REGION_EXACT;
				r = pt_y[mid];
			end else begin
				if (pt_x[mid] < q && mid < last)
					mid++;
				res.region = REGION_INTERP;
				span_pair(mid - 1, mid, pt_y[mid], q, r, zs);
			end
		end
		res.value     = r[VW-1:0];
		res.zero_span = zs;
		return res;
	endfunction

	always @(posedge clk) begin
		query_result_t exp_res;
		logic [5:0]    idx;
		longint        xv, yv;
		if (!arst_n) begin
			points_in_use = 2;
			awaited_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				points_in_use = int'(cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				idx = s_axis_tdata[5:0];
				xv  = longint'($signed(s_axis_tdata[37:6]));
				yv  = longint'($signed(s_axis_tdata[69:38]));
				if (cmd_t'(s_axis_tuser[0]) == CMD_WRITE) begin
					pt_x[idx] = xv;
					pt_y[idx] = yv;
				end else begin
					awaited_results.push_back(predict_query(xv));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: interpolated_value %0d, region %0d",
						$signed(m_axis_tdata[31:0]), m_axis_tuser[1:0]);
					mismatches++;
				end else begin
					exp_res = awaited_results.pop_front();
					if (m_axis_tdata[31:0] !== exp_res.value) begin
						$error("interpolated_value: expected %0d, got %0d",
							$signed(exp_res.value), $signed(m_axis_tdata[31:0]));
						mismatches++;
					end
					if (m_axis_tuser[1:0] !== exp_res.region) begin
						$error("region: expected %0d, got %0d", exp_res.region,
							m_axis_tuser[1:0]);
						mismatches++;
					end
					if (m_axis_tuser[2] !== exp_res.zero_span) begin
						$error("zero_span: expected %0d, got %0d", exp_res.zero_span,
							m_axis_tuser[2]);
						mismatches++;
					end
				end
			end
			outstanding = awaited_results.size();
		end
	end

endmodule

// File: bench/tb_top.sv
module tb_top;
	import tli_pkg::*;

	localparam int CYCLE_LIMIT       = 1_000_000;
	localparam int PHASES            = 14;
	localparam int QUERIES_PER_PHASE = 80;
	// settle time after the last result, so a trailing write lands too
	localparam int SETTLE_CYCLES     = 60;
	localparam int PLANNED_LENGTHS   = 8;
	// extremes first, then a mix of in-range lengths and out-of-range values that the block clamps
	localparam int LENGTH_PLAN [PLANNED_LENGTHS] = '{64, 2, 0, 127, 17, 1, 65, 3};

	typedef enum int {
		TBL_WIDE,
		TBL_NARROW,
		TBL_REPEATS,
		TBL_SHUFFLED,
		TBL_GRID
	} table_shape_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [LEN_W-1:0]      cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	int mismatches;
	int outstanding;
	int cycles      = 0;
	int ready_hold  = 0;
	bit calm        = 1'b0;
	int live_points = 2;
	int shadow_x [64];

	always #2 clk = ~clk;

	table_linear_interpolator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	interp_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one; none at all in calm phases.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result side back-pressure: stall runs land on any cycle of a query.
	always @(negedge clk) begin
		if (calm || !arst_n) begin
			m_axis_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			m_axis_tready <= 1'b0;
			ready_hold    <= ready_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 99) < 25)
				ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
					$urandom_range(1, 3);
		end
	end

	function automatic int to_q32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return int'(v);
	endfunction

	// Present one transaction and hold it until accepted. Valid stays high
	// into the next call so back-to-back items need no extra edge.
	task automatic send_item(cmd_t cmd, logic [5:0] idx, logic [31:0] xv, logic [31:0] yv);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, yv, xv, idx};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic write_point(int idx, int xv, int yv);
		shadow_x[idx] = xv;
		send_item(CMD_WRITE, idx[5:0], xv, yv);
	endtask

	// Index and ordinate are ignored on a query; randomize them anyway.
	task automatic query(int q);
		send_item(CMD_QUERY, 6'($urandom), q, $urandom);
	endtask

	// Drop valid, wait for every awaited result, then let a trailing write land.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_length(int len);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= len[LEN_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid   <= 1'b0;
		live_points = (len < 2) ? 2 : (len > 64) ? 64 : len;
	endtask

	// Rewrite every point in use so no query reads an unwritten slot.
	task automatic load_table(table_shape_t shape);
		int xs [$];
		int n, v, yv, base, step;
		n    = live_points;
		base = int'($urandom_range(0, 1 << 17)) - (1 << 16);
		step = 65536 * $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			case (shape)
				TBL_NARROW: v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
				TBL_GRID:   v = base + i * step;
				default:    v = $urandom;
			endcase
			xs.push_back(v);
		end
		if (shape != TBL_SHUFFLED)
			xs.sort();
		if (shape == TBL_REPEATS) begin
			for (int i = 1; i < n; i++)
				if ($urandom_range(0, 3) == 0)
					xs[i] = xs[i-1];
		end
		for (int i = 0; i < n; i++) begin
			if (shape == TBL_WIDE || shape == TBL_SHUFFLED)
				yv = $urandom;
			else
				yv = int'($urandom_range(0, 1 << 23)) - (1 << 22);
			write_point(i, xs[i], yv);
		end
	endtask

	// Mix exact hits, points between neighbors, both outer sides and raw values.
	function automatic int pick_query();
		int     r, i, last;
		longint lo, hi;
		last = live_points - 1;
		r    = $urandom_range(0, 99);
		if (r < 30)
			return shadow_x[$urandom_range(0, last)];
		if (r < 65) begin
			i  = $urandom_range(0, last - 1);
			lo = shadow_x[i];
			hi = shadow_x[i+1];
			if (hi <= lo)
				return int'(lo);
			return int'(lo + 1 + longint'($urandom) % (hi - lo));
		end
		if (r < 75)
			return to_q32(longint'(shadow_x[0]) - longint'($urandom_range(0, 1 << 20)));
		if (r < 85)
			return to_q32(longint'(shadow_x[last]) + longint'($urandom_range(0, 1 << 20)));
		if (r < 92)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return shadow_x[0];
			default: return shadow_x[last];
		endcase
	endfunction

	initial begin
		int           len, idx;
		table_shape_t shape;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset length of two points.
		write_point(0, 0, 0);
		write_point(1, 1, 32'h7fff_ffff);
		query(32'h8000_0000);   // far below, steep slope: saturate low
		query(32'h7fff_ffff);   // far above: saturate high
		query(0);               // equal to first x counts as below
		query(1);               // exact hit on the last point
		write_point(0, 32'hffff_0000, 32'h8000_0000);
		write_point(1, 32'h0001_0000, 32'h7fff_ffff);
		query(0);               // between the two points
		query(32'hfffe_0000);
		query(32'h0002_0000);
		write_point(1, 32'hffff_0000, 32'h1234_5678);
		query(0);               // equal x pair from above
		query(32'hffff_0000);   // equal x pair from below
		query(32'h8000_0000);
		write_point(1, 32'h8000_0000, 0);
		query(0);               // descending pair, above side
		query(32'hfffe_7960);   // descending pair, below side
		write_point(0, 32'h7fff_ffff, 32'hffff_ffff);
		query(32'h8000_0000);
		query(32'h7fff_ffff);
		query(32'h0000_8000);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			len = (p < PLANNED_LENGTHS) ? LENGTH_PLAN[p] :
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 40);
			set_length(len);
			calm = (p % 5 == 3);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: shape = TBL_WIDE;
				4, 5:       shape = TBL_NARROW;
				6, 7:       shape = TBL_REPEATS;
				8:          shape = TBL_SHUFFLED;
				default:    shape = TBL_GRID;
			endcase
			load_table(shape);
			for (int k = 0; k < QUERIES_PER_PHASE; k++) begin
				// Now and then nudge a point while queries are in flight.
				if ($urandom_range(0, 19) == 0) begin
					idx = $urandom_range(0, live_points - 1);
					write_point(idx, to_q32(longint'(shadow_x[idx]) +
						longint'($urandom_range(0, 512)) - 256), $urandom);
				end
				query(pick_query());
			end
		end
		drain();

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
